>>> hw/rtl/hkrb_pkg.sv
// Shared types and constants for the HID key report builder.
`default_nettype none

package hkrb_pkg;

  localparam int unsigned SLOT_COUNT_DEF   = 6;
  localparam int unsigned BITMAP_BYTES_DEF = 14;

  localparam int unsigned SHOWN_SLOT_BITS  = 48;
  localparam int unsigned HALF_BITS        = 56;
  localparam int unsigned SHOWN_MAP_BITS   = 2 * HALF_BITS;

  localparam logic [1:0] CMD_KEY   = 2'd0;
  localparam logic [1:0] CMD_MOD   = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  localparam logic [7:0] MOD_FIRST     = 8'hE0;
  localparam logic [7:0] EMPTY_SLOT    = 8'h00;
  localparam logic [7:0] NKRO_ID_RESET = 8'h04;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] keycode;
    logic       pressed;
  } item_t;

  typedef struct packed {
    logic [7:0]  modifier_bits;
    logic [47:0] slot_bytes;
    logic [7:0]  nkro_id_byte;
    logic [55:0] nkro_bits_low;
    logic [55:0] nkro_bits_high;
    logic        went_to_nkro;
  } result_t;

  typedef enum logic {
    ST_IDLE,
    ST_HOLD
  } state_e;

  typedef struct packed {
    logic exec;
    logic cfg_write;
  } dp_cmd_t;

endpackage

`default_nettype wire

>>> hw/rtl/hkrb_ctrl.sv
// Handshake controller: accepts items and holds the result until taken.
`default_nettype none

module hkrb_ctrl (
  input  wire             clk_i,
  input  wire             rst_ni,
  input  wire             in_valid_i,
  output logic            in_stall_o,
  output logic            out_valid_o,
  input  wire             out_stall_i,
  input  wire             cfg_valid_i,
  output hkrb_pkg::dp_cmd_t cmd_o
);
  import hkrb_pkg::*;

  state_e state_q, state_d;
  logic   accept;

  assign accept = in_valid_i && !in_stall_o;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) state_d = ST_HOLD;
      end
      ST_HOLD: begin
        if (accept) state_d = ST_HOLD;
        else if (!out_stall_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // a new item may enter in the cycle the held result leaves
  always_comb begin
    in_stall_o    = 1'b0;
    out_valid_o   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_stall_o  = 1'b0;
        out_valid_o = 1'b0;
      end
      ST_HOLD: begin
        in_stall_o  = out_stall_i;
        out_valid_o = 1'b1;
      end
      default: begin
        in_stall_o  = 1'b1;
        out_valid_o = 1'b0;
      end
    endcase
    cmd_o.exec      = in_valid_i && !in_stall_o;
    cmd_o.cfg_write = cfg_valid_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/hkrb_dp.sv
// Report datapath: key slots, modifier byte, NKRO bitmap and ID byte.
`default_nettype none

module hkrb_dp #(
  parameter int unsigned SLOT_COUNT   = hkrb_pkg::SLOT_COUNT_DEF,
  parameter int unsigned BITMAP_BYTES = hkrb_pkg::BITMAP_BYTES_DEF
) (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  hkrb_pkg::dp_cmd_t cmd_i,
  input  hkrb_pkg::item_t   item_i,
  input  wire  [7:0]        cfg_data_i,
  output hkrb_pkg::result_t result_o
);
  import hkrb_pkg::*;

  localparam int unsigned BmBits    = BITMAP_BYTES * 8;
  localparam int unsigned SlotBits  = SLOT_COUNT * 8;
  localparam int unsigned SlotPad   = (SlotBits > SHOWN_SLOT_BITS) ? SlotBits : SHOWN_SLOT_BITS;
  localparam int unsigned MapPad    = (BmBits > SHOWN_MAP_BITS) ? BmBits : SHOWN_MAP_BITS;

  logic [7:0]        slot_q [SLOT_COUNT];
  logic [7:0]        slot_d [SLOT_COUNT];
  logic [BmBits-1:0] bm_q, bm_d;
  logic [7:0]        mod_q, mod_d;
  logic [7:0]        id_q, id_d;
  logic [7:0]        cfg_q;
  logic              went_q;

  logic [SLOT_COUNT-1:0] hit;
  logic                  seen;
  logic                  is_key, is_mod, is_clear;
  logic                  overflow, bm_wr, id_wr;
  logic [SlotBits-1:0]   slots_flat;
  logic [SlotPad-1:0]    slots_pad;
  logic [MapPad-1:0]     bm_pad;

  assign is_key   = item_i.command == CMD_KEY;
  assign is_mod   = item_i.command == CMD_MOD;
  assign is_clear = item_i.command == CMD_CLEAR;

  // first slot holding the keycode or, on a press, an empty one, whichever comes first
  always_comb begin
    hit  = '0;
    seen = 1'b0;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      if (!seen && (slot_q[i] == item_i.keycode ||
                    (item_i.pressed && slot_q[i] == EMPTY_SLOT))) begin
        hit[i] = 1'b1;
        seen   = 1'b1;
      end
    end
  end

  assign overflow = is_key && item_i.pressed && !seen;
  assign bm_wr    = is_key && (!item_i.pressed || overflow);
  assign id_wr    = bm_wr || is_clear;

  always_comb begin
    for (int i = 0; i < SLOT_COUNT; i++) begin
      if (is_clear) slot_d[i] = EMPTY_SLOT;
      else if (is_key && hit[i]) slot_d[i] = item_i.pressed ? item_i.keycode : EMPTY_SLOT;
      else slot_d[i] = slot_q[i];
    end
  end

  // keycodes past the bitmap match no bit and leave it alone
  always_comb begin
    for (int b = 0; b < BmBits; b++) begin
      if (is_clear) bm_d[b] = 1'b0;
      else if (bm_wr && item_i.keycode == 8'(b)) bm_d[b] = item_i.pressed;
      else bm_d[b] = bm_q[b];
    end
  end

  always_comb begin
    mod_d = mod_q;
    if (is_clear) begin
      mod_d = '0;
    end else if (is_mod && item_i.keycode[7:3] == MOD_FIRST[7:3]) begin
      mod_d[item_i.keycode[2:0]] = item_i.pressed;
    end
    id_d = id_wr ? cfg_q : id_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SLOT_COUNT; i++) slot_q[i] <= EMPTY_SLOT;
      bm_q   <= '0;
      mod_q  <= '0;
      id_q   <= '0;
      cfg_q  <= NKRO_ID_RESET;
      went_q <= 1'b0;
    end else begin
      if (cmd_i.exec) begin
        for (int i = 0; i < SLOT_COUNT; i++) slot_q[i] <= slot_d[i];
        bm_q   <= bm_d;
        mod_q  <= mod_d;
        id_q   <= id_d;
        went_q <= overflow;
      end
      if (cmd_i.cfg_write) cfg_q <= cfg_data_i;
    end
  end

  always_comb begin
    for (int i = 0; i < SLOT_COUNT; i++) slots_flat[i*8 +: 8] = slot_q[i];
  end

  assign slots_pad = SlotPad'(slots_flat);
  assign bm_pad    = MapPad'(bm_q);

  // state registers stay put while a result is held, so they are the output
  assign result_o.modifier_bits  = mod_q;
  assign result_o.slot_bytes     = slots_pad[SHOWN_SLOT_BITS-1:0];
  assign result_o.nkro_id_byte   = id_q;
  assign result_o.nkro_bits_low  = bm_pad[HALF_BITS-1:0];
  assign result_o.nkro_bits_high = bm_pad[SHOWN_MAP_BITS-1:HALF_BITS];
  assign result_o.went_to_nkro   = went_q;

endmodule

`default_nettype wire

>>> hw/rtl/hid_key_report_builder.sv
// HID keyboard report builder: boot report with six key slots plus NKRO bitmap.
// Input channel in_valid_i / in_stall_o carries one command item (key event,
// modifier event or clear). Output channel out_valid_o / out_stall_i carries
// the full report state after that item, plus the went_to_nkro flag.
// The result is valid in the cycle after acceptance. Unless the receiver stalls,
// throughput is one item per cycle; the slot scan (priority compare of all
// slots) and the bitmap bit update finish in the accepting cycle.
// While a result is held and the receiver stalls, in_stall_o is raised and
// no item enters; a new item may enter in the cycle the held result leaves.
// The config channel cfg_valid_i / cfg_ready_o writes the NKRO report ID;
// ready is always high, and writes are meant for idle periods only.
// Reset (rst_ni low, asynchronous) empties all slots, clears the modifier
// byte, bitmap and NKRO ID byte, and sets the report ID register to 4.
// Output fields follow the stored report, so they hold while stalled.
`default_nettype none

module hid_key_report_builder #(
  parameter int unsigned SLOT_COUNT   = hkrb_pkg::SLOT_COUNT_DEF,
  parameter int unsigned BITMAP_BYTES = hkrb_pkg::BITMAP_BYTES_DEF
) (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               in_valid_i,
  output logic              in_stall_o,
  input  hkrb_pkg::item_t   in_item_i,
  output logic              out_valid_o,
  input  wire               out_stall_i,
  output hkrb_pkg::result_t out_result_o,
  input  wire               cfg_valid_i,
  output logic              cfg_ready_o,
  input  wire  [7:0]        cfg_data_i
);
  import hkrb_pkg::*;

  dp_cmd_t cmd;

  assign cfg_ready_o = 1'b1;

  hkrb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cfg_valid_i (cfg_valid_i),
    .cmd_o       (cmd)
  );

  hkrb_dp #(
    .SLOT_COUNT   (SLOT_COUNT),
    .BITMAP_BYTES (BITMAP_BYTES)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .item_i     (in_item_i),
    .cfg_data_i (cfg_data_i),
    .result_o   (out_result_o)
  );

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> out_valid_o)
    else $error("accepted item produced no result");

  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && in_item_i.command == CMD_CLEAR |=>
      out_result_o.modifier_bits == '0 && out_result_o.slot_bytes == '0 &&
      out_result_o.nkro_bits_low == '0 && out_result_o.nkro_bits_high == '0 &&
      !out_result_o.went_to_nkro)
    else $error("clear left report state behind");

  a_mod_keeps_slots: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && in_item_i.command == CMD_MOD |=>
      $stable(out_result_o.slot_bytes) && !out_result_o.went_to_nkro)
    else $error("modifier item touched key slots");

  a_no_entry_when_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_result_o))
    else $error("held result changed under stall");

endmodule

`default_nettype wire

>>> verif/tb_top.sv
// Self-checking testbench for the HID key report builder: directed table, then random phases.
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import hkrb_pkg::*;

  localparam logic [1:0]  CMD_UNUSED   = 2'd3;
  localparam logic [7:0]  MOD_LAST     = 8'hE7;
  localparam int unsigned MAP_BITS     = BITMAP_BYTES_DEF * 8;
  localparam int unsigned SHOWN_SLOTS  = SHOWN_SLOT_BITS / 8;
  localparam int unsigned PHASE_ITEMS  = 150;
  localparam int unsigned DRAIN_CYCLES = 4;
  localparam int unsigned MAX_GAP      = 8;
  localparam int unsigned CYCLE_LIMIT  = 100000;

  typedef struct {
    item_t   it;
    bit      typed;
    result_t want;
  } dir_row_t;

  logic    clk = 1'b0;
  logic    rst_n = 1'b0;
  logic    in_valid = 1'b0;
  item_t   in_item = '0;
  logic    out_stall = 1'b0;
  logic    cfg_valid = 1'b0;
  logic    [7:0] cfg_data = '0;
  logic    in_stall;
  logic    out_valid;
  logic    cfg_ready;
  result_t out_result;

  // Model of the report state
  logic [7:0]                report_id = NKRO_ID_RESET;
  logic [7:0]                mod_byte = '0;
  logic [7:0]                slot_code [SLOT_COUNT_DEF];
  logic [SHOWN_MAP_BITS-1:0] nkro_map = '0;
  logic [7:0]                nkro_id = '0;

  result_t     pending_reports [$];
  dir_row_t    dir_rows [$];
  int unsigned gap_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned cycle_cnt = 0;
  int unsigned err_cnt = 0;
  int unsigned items_sent = 0;
  int unsigned reports_seen = 0;
  int unsigned overflow_seen = 0;
  int unsigned id_writes = 0;
  logic [7:0]  key_pool [10];

  hid_key_report_builder u_top (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .in_item_i    (in_item),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .out_result_o (out_result),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready),
    .cfg_data_i   (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // Report checker: every report leaving the block is matched against the oldest prediction
  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (pending_reports.size() == 0) begin
        $error("report with no item outstanding: %h", out_result);
        err_cnt++;
      end else begin
        want = pending_reports.pop_front();
        reports_seen++;
        if (out_result.went_to_nkro === 1'b1) overflow_seen++;
        if (out_result.modifier_bits !== want.modifier_bits) begin
          $error("modifier_bits: expected %h, got %h", want.modifier_bits,
                 out_result.modifier_bits);
          err_cnt++;
        end
        if (out_result.slot_bytes !== want.slot_bytes) begin
          $error("slot_bytes: expected %h, got %h", want.slot_bytes, out_result.slot_bytes);
          err_cnt++;
        end
        if (out_result.nkro_id_byte !== want.nkro_id_byte) begin
          $error("nkro_id_byte: expected %h, got %h", want.nkro_id_byte,
                 out_result.nkro_id_byte);
          err_cnt++;
        end
        if (out_result.nkro_bits_low !== want.nkro_bits_low) begin
          $error("nkro_bits_low: expected %h, got %h", want.nkro_bits_low,
                 out_result.nkro_bits_low);
          err_cnt++;
        end
        if (out_result.nkro_bits_high !== want.nkro_bits_high) begin
          $error("nkro_bits_high: expected %h, got %h", want.nkro_bits_high,
                 out_result.nkro_bits_high);
          err_cnt++;
        end
        if (out_result.went_to_nkro !== want.went_to_nkro) begin
          $error("went_to_nkro: expected %b, got %b", want.went_to_nkro,
                 out_result.went_to_nkro);
          err_cnt++;
        end
      end
    end
  end

  // Advances the model by one item and returns the report shown afterwards
  function automatic result_t next_report(input item_t it);
    result_t r;
    logic    hit;
    r   = '0;
    hit = 1'b0;
    case (it.command)
      CMD_KEY: begin
        if (it.pressed) begin
          // an empty slot and a held copy of the key both end the scan
          for (int i = 0; i < SLOT_COUNT_DEF && !hit; i++) begin
            if (slot_code[i] == it.keycode) begin
              hit = 1'b1;
            end else if (slot_code[i] == EMPTY_SLOT) begin
              slot_code[i] = it.keycode;
              hit = 1'b1;
            end
          end
          if (!hit) begin
            r.went_to_nkro = 1'b1;
            nkro_id = report_id;
            if (it.keycode < MAP_BITS) nkro_map[7'(it.keycode)] = 1'b1;
          end
        end else begin
          for (int i = 0; i < SLOT_COUNT_DEF && !hit; i++) begin
            if (slot_code[i] == it.keycode) begin
              slot_code[i] = EMPTY_SLOT;
              hit = 1'b1;
            end
          end
          nkro_id = report_id;
          if (it.keycode < MAP_BITS) nkro_map[7'(it.keycode)] = 1'b0;
        end
      end
      CMD_MOD: begin
        if (it.keycode >= MOD_FIRST && it.keycode <= MOD_LAST)
          mod_byte[it.keycode[2:0]] = it.pressed;
      end
      CMD_CLEAR: begin
        mod_byte = '0;
        for (int i = 0; i < SLOT_COUNT_DEF; i++) slot_code[i] = EMPTY_SLOT;
        nkro_map = '0;
        nkro_id  = report_id;
      end
      default: ;
    endcase
    r.modifier_bits = mod_byte;
    for (int i = 0; i < SLOT_COUNT_DEF && i < SHOWN_SLOTS; i++)
      r.slot_bytes[8*i +: 8] = slot_code[i];
    r.nkro_id_byte   = nkro_id;
    r.nkro_bits_low  = nkro_map[HALF_BITS-1:0];
    r.nkro_bits_high = nkro_map[SHOWN_MAP_BITS-1:HALF_BITS];
    return r;
  endfunction

  task automatic add_row(input logic [1:0] cmd, input logic [7:0] key, input logic prs,
                         input bit typed, input result_t want);
    dir_row_t row;
    row.it.command = cmd;
    row.it.keycode = key;
    row.it.pressed = prs;
    row.typed      = typed;
    row.want       = want;
    dir_rows.push_back(row);
  endtask

  // Offers one item after a random gap and waits until the block takes it
  task automatic send_item(input item_t it, input bit typed, input result_t want);
    int unsigned gap;
    result_t     pred;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < gap_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (in_stall !== 1'b0);
    pred = next_report(it);
    pending_reports.push_back(typed ? want : pred);
    items_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_report_id(input logic [7:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    report_id = value;
    id_writes++;
    cfg_valid <= 1'b0;
  endtask

  initial begin
    item_t       it;
    int unsigned r;
    int unsigned base;
    logic [7:0]  id_vals [4];

    for (int i = 0; i < SLOT_COUNT_DEF; i++) slot_code[i] = EMPTY_SLOT;

    // Reset state, keycode zero, modifier range edges
    add_row(CMD_UNUSED, 8'hFF, 1'b1, 1, '0);
    add_row(CMD_KEY,   8'h00, 1'b1, 1, '0);
    add_row(CMD_KEY,   8'h00, 1'b0, 1, {8'h00, 48'h0, 8'h04, 56'h0, 56'h0, 1'b0});
    add_row(CMD_MOD,   8'hE0, 1'b1, 1, {8'h01, 48'h0, 8'h04, 56'h0, 56'h0, 1'b0});
    add_row(CMD_MOD,   8'hE7, 1'b1, 1, {8'h81, 48'h0, 8'h04, 56'h0, 56'h0, 1'b0});
    add_row(CMD_MOD,   8'hDF, 1'b1, 0, '0);
    add_row(CMD_MOD,   8'hE8, 1'b0, 0, '0);
    add_row(CMD_MOD,   8'hE0, 1'b0, 1, {8'h80, 48'h0, 8'h04, 56'h0, 56'h0, 1'b0});
    // Fill all slots, then overflow into the bitmap
    add_row(CMD_KEY,   8'h04, 1'b1, 0, '0);
    add_row(CMD_KEY,   8'h05, 1'b1, 0, '0);
    add_row(CMD_KEY,   8'h06, 1'b1, 0, '0);
    add_row(CMD_KEY,   8'h07, 1'b1, 0, '0);
    add_row(CMD_KEY,   8'h08, 1'b1, 0, '0);
    add_row(CMD_KEY,   8'h09, 1'b1, 1,
            {8'h80, 48'h09_08_07_06_05_04, 8'h04, 56'h0, 56'h0, 1'b0});
    add_row(CMD_KEY,   8'h05, 1'b1, 0, '0);
    // key past the bitmap: flag only
    add_row(CMD_KEY,   8'hFF, 1'b1, 1,
            {8'h80, 48'h09_08_07_06_05_04, 8'h04, 56'h0, 56'h0, 1'b1});
    add_row(CMD_KEY,   8'h6F, 1'b1, 0, '0);
    add_row(CMD_KEY,   8'h37, 1'b1, 0, '0);
    add_row(CMD_KEY,   8'h38, 1'b1, 0, '0);
    add_row(CMD_KEY,   8'h06, 1'b0, 0, '0);
    add_row(CMD_KEY,   8'h70, 1'b1, 0, '0);
    add_row(CMD_KEY,   8'h6F, 1'b0, 0, '0);
    add_row(CMD_KEY,   8'hFF, 1'b0, 0, '0);
    add_row(CMD_MOD,   8'hE7, 1'b0, 0, '0);
    add_row(CMD_CLEAR, 8'hA5, 1'b1, 1, {8'h00, 48'h0, 8'h04, 56'h0, 56'h0, 1'b0});

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    gap_pct   = 38;
    stall_pct = 38;
    foreach (dir_rows[k]) send_item(dir_rows[k].it, dir_rows[k].typed, dir_rows[k].want);
    drain();

    id_vals[0] = 8'h00;
    id_vals[1] = 8'hFF;
    id_vals[2] = 8'($urandom_range(255));
    id_vals[3] = 8'($urandom_range(255));

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 54; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 54; end
        default: begin gap_pct = 38; stall_pct = 38; end
      endcase
      write_report_id(id_vals[ph]);
      // a small pool of keys keeps slots full and overflows frequent
      base = (ph == 2) ? 104 : $urandom_range(246);
      for (int i = 0; i < 10; i++) key_pool[i] = 8'(base + i);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        r = $urandom_range(99);
        it.pressed = ($urandom_range(99) < 60);
        if (r < 55) begin
          it.command = CMD_KEY;
          it.keycode = key_pool[4'($urandom_range(9))];
        end else if (r < 72) begin
          it.command = CMD_KEY;
          it.keycode = 8'($urandom_range(255));
        end else if (r < 93) begin
          it.command = CMD_MOD;
          it.keycode = ($urandom_range(99) < 80) ? 8'(MOD_FIRST + $urandom_range(7))
                                                 : 8'($urandom_range(255));
        end else if (r < 96) begin
          it.command = CMD_CLEAR;
          it.keycode = 8'($urandom_range(255));
        end else begin
          it.command = 2'($urandom_range(3));
          it.keycode = 8'($urandom_range(255));
          it.pressed = 1'($urandom_range(1));
        end
        send_item(it, 0, '0);
      end
      drain();
    end

    $display("Sent %0d items and checked %0d reports across four idle/stall phases",
             items_sent, reports_seen);
    $display("%0d presses went to the NKRO bitmap; report ID written %0d times",
             overflow_seen, id_writes);
    if (err_cnt == 0 && pending_reports.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
